@@ rtl/nub_pkg.sv @@
// Shared types and constants for the nearest up-left bank select block.
`timescale 1ns / 1ps

package nub_pkg;

  localparam int MAX_CHANNELS = 16;  // table depth and search chain length
  localparam int IDX_BITS = 4;  // bank / channel index width
  localparam int CNT_BITS = 5;  // channel_count register width

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(1);

  // Control half of the search token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                seeded;    // best has been taken from entry 0
    logic                best_ok;   // current best lies up-left of the worker
    logic [IDX_BITS-1:0] best_idx;
    logic [CNT_BITS-1:0] count;     // saturated number of entries to search
  } nub_ctl_t;

endpackage

@@ rtl/nub_cell.sv @@
// One search cell: holds one channel coordinate and updates the passing token.
`timescale 1ns / 1ps

module nub_cell #(
  parameter int COORD_BITS = 6,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         ld_en,
  input  logic [nub_pkg::IDX_BITS-1:0] ld_idx,
  input  logic [COORD_BITS-1:0]        ld_x,
  input  logic [COORD_BITS-1:0]        ld_y,
  input  nub_pkg::nub_ctl_t            tin_ctl,
  input  logic [COORD_BITS-1:0]        tin_wx,
  input  logic [COORD_BITS-1:0]        tin_wy,
  input  logic [COORD_BITS-1:0]        tin_bx,
  input  logic [COORD_BITS-1:0]        tin_by,
  input  logic [COORD_BITS:0]          tin_dist,
  output nub_pkg::nub_ctl_t            tout_ctl,
  output logic [COORD_BITS-1:0]        tout_wx,
  output logic [COORD_BITS-1:0]        tout_wy,
  output logic [COORD_BITS-1:0]        tout_bx,
  output logic [COORD_BITS-1:0]        tout_by,
  output logic [COORD_BITS:0]          tout_dist
);

  logic [COORD_BITS-1:0] ex;
  logic [COORD_BITS-1:0] ey;
  logic                  cand_ok;
  logic [COORD_BITS:0]   cand_dist;
  logic                  active;
  logic                  take;
  nub_pkg::nub_ctl_t     ctl_next;

  always_ff @(posedge clk) begin
    if (ld_en && ld_idx == nub_pkg::IDX_BITS'(INDEX)) begin
      ex <= ld_x;
      ey <= ld_y;
    end
  end

  always_comb begin
    cand_ok   = (ex <= tin_wx) && (ey <= tin_wy);
    // only meaningful when cand_ok (no borrow)
    cand_dist = {1'b0, tin_wx - ex} + {1'b0, tin_wy - ey};
    active    = INDEX < int'(tin_ctl.count);
    // first cell seeds the best with its own entry
    take      = !tin_ctl.seeded ||
                (active && cand_ok && (!tin_ctl.best_ok || cand_dist < tin_dist));
    ctl_next        = tin_ctl;
    ctl_next.seeded = 1'b1;
    if (take) begin
      ctl_next.best_ok  = cand_ok;
      ctl_next.best_idx = nub_pkg::IDX_BITS'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_ctl.valid <= 1'b0;
    end else if (adv) begin
      tout_ctl.valid <= tin_ctl.valid;
    end
    if (adv) begin
      tout_ctl.seeded   <= ctl_next.seeded;
      tout_ctl.best_ok  <= ctl_next.best_ok;
      tout_ctl.best_idx <= ctl_next.best_idx;
      tout_ctl.count    <= ctl_next.count;
      tout_wx           <= tin_wx;
      tout_wy           <= tin_wy;
      tout_bx           <= take ? ex : tin_bx;
      tout_by           <= take ? ey : tin_by;
      tout_dist         <= take ? cand_dist : tin_dist;
    end
  end

endmodule

@@ rtl/nearest_upleft_bank_select_top.sv @@
// Top level of the nearest up-left bank select block.
`timescale 1ns / 1ps

// A load beat writes one channel coordinate into its cell.
// A query beat enters a chain of MAX_CHANNELS cells, one cell per cycle, and its
// result then passes from the last cell into the output register; no further
// beat, load or query, is accepted while a query is in the chain, and the block
// stays busy while the finished token waits for an earlier result to leave the
// output. The chain length, not channel_count, sets the query latency. Loads are
// accepted while a finished result still waits on the output.
module nearest_upleft_bank_select_top #(
  parameter int COORD_BITS   = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [nub_pkg::IDX_BITS-1:0] channel_index,
  input  logic [COORD_BITS-1:0]        coord_x,
  input  logic [COORD_BITS-1:0]        coord_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nub_pkg::IDX_BITS-1:0] bank_index,
  output logic [COORD_BITS-1:0]        bank_x,
  output logic [COORD_BITS-1:0]        bank_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nub_pkg::CNT_BITS-1:0] cfg_data
);

  localparam int MAX_CHANNELS = nub_pkg::MAX_CHANNELS;

  logic [nub_pkg::CNT_BITS-1:0] channel_count;
  logic [nub_pkg::CNT_BITS-1:0] count_sat;
  logic                         busy;
  logic                         in_beat;
  logic                         ld_en;
  logic                         query_beat;
  logic                         adv;
  logic                         done;

  nub_pkg::nub_ctl_t     ctl       [MAX_CHANNELS+1];
  logic [COORD_BITS-1:0] wx        [MAX_CHANNELS+1];
  logic [COORD_BITS-1:0] wy        [MAX_CHANNELS+1];
  logic [COORD_BITS-1:0] bx        [MAX_CHANNELS+1];
  logic [COORD_BITS-1:0] by        [MAX_CHANNELS+1];
  logic [COORD_BITS:0]   best_dist [MAX_CHANNELS+1];
  logic [MAX_CHANNELS-1:0] chain_valid;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !busy;
  assign in_beat    = in_valid && in_ready;
  assign ld_en      = in_beat && (kind == nub_pkg::KIND_LOAD);
  assign query_beat = in_beat && (kind == nub_pkg::KIND_QUERY);

  assign count_sat = (int'(channel_count) > MAX_CHANNELS) ?
                     nub_pkg::CNT_BITS'(MAX_CHANNELS) : channel_count;

  // chain freezes while the finished token waits for the output register
  assign done = ctl[MAX_CHANNELS].valid;
  assign adv  = !(done && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= nub_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      channel_count <= cfg_data;
    end
  end

  always_comb begin
    ctl[0].valid    = query_beat;
    ctl[0].seeded   = 1'b0;
    ctl[0].best_ok  = 1'b0;
    ctl[0].best_idx = '0;
    ctl[0].count    = count_sat;
    wx[0]           = coord_x;
    wy[0]           = coord_y;
    bx[0]           = '0;
    by[0]           = '0;
    best_dist[0]    = '0;
  end

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    nub_cell #(
      .COORD_BITS(COORD_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ld_en    (ld_en),
      .ld_idx   (channel_index),
      .ld_x     (coord_x),
      .ld_y     (coord_y),
      .tin_ctl  (ctl[i]),
      .tin_wx   (wx[i]),
      .tin_wy   (wy[i]),
      .tin_bx   (bx[i]),
      .tin_by   (by[i]),
      .tin_dist (best_dist[i]),
      .tout_ctl (ctl[i+1]),
      .tout_wx  (wx[i+1]),
      .tout_wy  (wy[i+1]),
      .tout_bx  (bx[i+1]),
      .tout_by  (by[i+1]),
      .tout_dist(best_dist[i+1])
    );
    assign chain_valid[i] = ctl[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (query_beat) begin
        busy <= 1'b1;
      end else if (done && adv) begin
        busy <= 1'b0;
      end
      if (done && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && adv) begin
      bank_index <= ctl[MAX_CHANNELS].best_idx;
      bank_x     <= bx[MAX_CHANNELS];
      bank_y     <= by[MAX_CHANNELS];
    end
  end

  // at most one query travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one query token in the chain");

  a_busy_set: assert property (@(posedge clk) disable iff (rst)
    query_beat |=> busy)
    else $error("query accepted but block not busy");

  a_busy_covers_chain: assert property (@(posedge clk) disable iff (rst)
    (chain_valid != '0) |-> busy)
    else $error("token in chain while block idle");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (done && adv) |=> (out_valid && !busy))
    else $error("finished token not moved to the output");

endmodule
